// ===== hdl/grid_astar_path_search_macros.svh =====
// Assertion macros for the grid path search block.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef GRID_ASTAR_PATH_SEARCH_MACROS_SVH
`define GRID_ASTAR_PATH_SEARCH_MACROS_SVH

// Checked out of reset only.
`define GAP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define GAP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hdl/gap_pkg.sv =====
// Shared types, constants and helper functions of the grid path search block.
// No dependencies.
package gap_pkg;

  localparam int unsigned GRID_SIDE = 64;
  localparam int unsigned CELLS     = GRID_SIDE * GRID_SIDE;
  localparam int unsigned COORD_W   = $clog2(GRID_SIDE);
  localparam int unsigned ADDR_W    = $clog2(CELLS);
  localparam int unsigned FIELD_W   = 6;
  localparam int unsigned COST_W    = 12;
  localparam int unsigned EST_W     = 13;
  localparam int unsigned ORD_W     = 12;
  localparam int unsigned LEN_W     = 12;

  localparam logic [FIELD_W-1:0] GOAL_RESET = FIELD_W'(GRID_SIDE - 1);

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_SEARCH = 2'd1,
    REQ_READ   = 2'd2
  } gap_req_e;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FOUND = 2'd1,
    STATUS_NONE  = 2'd2
  } gap_status_e;

  typedef enum logic [2:0] {
    DIR_NONE    = 3'd0,
    DIR_ROW_INC = 3'd1,
    DIR_ROW_DEC = 3'd2,
    DIR_COL_INC = 3'd3,
    DIR_COL_DEC = 3'd4
  } gap_dir_e;

  typedef enum logic [1:0] {
    NB_ROW_INC = 2'd0,
    NB_ROW_DEC = 2'd1,
    NB_COL_INC = 2'd2,
    NB_COL_DEC = 2'd3
  } gap_nb_e;

  typedef enum logic [1:0] {
    CFG_START_ROW = 2'd0,
    CFG_START_COL = 2'd1,
    CFG_GOAL_ROW  = 2'd2,
    CFG_GOAL_COL  = 2'd3
  } gap_cfg_idx_e;

  typedef enum logic [3:0] {
    S_INIT_CLR,
    S_IDLE,
    S_READ,
    S_RESP,
    S_CLR,
    S_START,
    S_SCAN,
    S_DECIDE,
    S_NB_RD,
    S_NB_WR,
    S_TR_RD,
    S_TR_WR
  } gap_state_e;

  typedef struct packed {
    logic               open_f;
    logic               closed_f;
    logic               path_f;
    gap_dir_e           came;
    logic [COST_W-1:0]  cost;
    logic [EST_W-1:0]   est;
    logic [ORD_W-1:0]   order;
  } gap_cell_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [FIELD_W-1:0] row_index;
    logic [FIELD_W-1:0] col_index;
    logic               wall_bit;
  } gap_req_t;

  typedef struct packed {
    logic [FIELD_W-1:0] start_row;
    logic [FIELD_W-1:0] start_col;
    logic [FIELD_W-1:0] goal_row;
    logic [FIELD_W-1:0] goal_col;
  } gap_cfg_t;

  typedef struct packed {
    gap_status_e        status;
    logic [LEN_W-1:0]   path_length;
    logic               cell_closed;
    logic               cell_open;
    logic               cell_on_path;
    gap_dir_e           came;
    logic [COST_W-1:0]  cost;
  } gap_result_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] r,
                                                  input logic [COORD_W-1:0] c);
    return ADDR_W'(r * GRID_SIDE + c);
  endfunction

  function automatic logic [EST_W-1:0] manhattan(input logic [COORD_W-1:0] r,
                                                 input logic [COORD_W-1:0] c,
                                                 input logic [COORD_W-1:0] gr,
                                                 input logic [COORD_W-1:0] gc);
    logic [COORD_W-1:0] dr;
    logic [COORD_W-1:0] dc;
    dr = (r > gr) ? r - gr : gr - r;
    dc = (c > gc) ? c - gc : gc - c;
    return EST_W'(dr) + EST_W'(dc);
  endfunction

endpackage

// ===== hdl/gap_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module gap_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hdl/gap_engine.sv =====
// Search sequencer: owns the wall and cell memories and runs loads, reads and searches.
// Depends on gap_pkg, gap_ram and the assertion macros header.
`include "grid_astar_path_search_macros.svh"

module gap_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  gap_pkg::gap_req_t    req_i,
  input  gap_pkg::gap_cfg_t    cfg_i,
  output logic                 idle_o,
  output logic                 res_valid_o,
  output gap_pkg::gap_result_t res_o
);
  import gap_pkg::*;

  gap_state_e          state_q, state_d;
  logic [ADDR_W:0]     addr_q, addr_d;
  logic                rd_vld_q, rd_vld_d;
  logic                best_any_q, best_any_d;
  logic [ORD_W:0]      ins_cnt_q, ins_cnt_d;
  logic [LEN_W-1:0]    last_len_q, last_len_d;
  gap_nb_e             dir_q, dir_d;
  logic [ADDR_W-1:0]   tr_cnt_q, tr_cnt_d;
  logic                rd_in_q, rd_in_d;

  logic [COORD_W-1:0]  scan_row_q, scan_row_d, scan_col_q, scan_col_d;
  logic [COORD_W-1:0]  rd_row_q, rd_row_d, rd_col_q, rd_col_d;
  gap_cell_t           best_q, best_d;
  logic [COORD_W-1:0]  best_row_q, best_row_d, best_col_q, best_col_d;
  logic [COORD_W-1:0]  nb_row_q, nb_row_d, nb_col_q, nb_col_d;
  gap_result_t         res_q, res_d;

  logic                cell_we, cell_re;
  logic [ADDR_W-1:0]   cell_waddr, cell_raddr;
  gap_cell_t           cell_wdata, cell_rdata;
  logic                wall_we, wall_re;
  logic [ADDR_W-1:0]   wall_waddr, wall_raddr;
  logic                wall_wdata, wall_rdata;

  logic [COORD_W-1:0]  s_row, s_col, g_row, g_col;
  logic [ADDR_W-1:0]   s_addr, g_addr;
  logic                ends_in;

  gap_ram #(.WIDTH($bits(gap_cell_t)), .DEPTH(CELLS)) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (cell_waddr),
    .wdata_i (cell_wdata),
    .re_i    (cell_re),
    .raddr_i (cell_raddr),
    .rdata_o (cell_rdata)
  );

  gap_ram #(.WIDTH(1), .DEPTH(CELLS)) u_wall_ram (
    .clk_i   (clk_i),
    .we_i    (wall_we),
    .waddr_i (wall_waddr),
    .wdata_i (wall_wdata),
    .re_i    (wall_re),
    .raddr_i (wall_raddr),
    .rdata_o (wall_rdata)
  );

  assign s_row   = COORD_W'(cfg_i.start_row);
  assign s_col   = COORD_W'(cfg_i.start_col);
  assign g_row   = COORD_W'(cfg_i.goal_row);
  assign g_col   = COORD_W'(cfg_i.goal_col);
  assign s_addr  = cell_addr(s_row, s_col);
  assign g_addr  = cell_addr(g_row, g_col);
  assign ends_in = (cfg_i.start_row < GRID_SIDE) && (cfg_i.start_col < GRID_SIDE) &&
                   (cfg_i.goal_row < GRID_SIDE) && (cfg_i.goal_col < GRID_SIDE);

  assign idle_o      = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESP);
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT_CLR;
      addr_q     <= '0;
      rd_vld_q   <= 1'b0;
      best_any_q <= 1'b0;
      ins_cnt_q  <= '0;
      last_len_q <= '0;
      dir_q      <= NB_ROW_INC;
      tr_cnt_q   <= '0;
      rd_in_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      addr_q     <= addr_d;
      rd_vld_q   <= rd_vld_d;
      best_any_q <= best_any_d;
      ins_cnt_q  <= ins_cnt_d;
      last_len_q <= last_len_d;
      dir_q      <= dir_d;
      tr_cnt_q   <= tr_cnt_d;
      rd_in_q    <= rd_in_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_row_q <= scan_row_d;
    scan_col_q <= scan_col_d;
    rd_row_q   <= rd_row_d;
    rd_col_q   <= rd_col_d;
    best_q     <= best_d;
    best_row_q <= best_row_d;
    best_col_q <= best_col_d;
    nb_row_q   <= nb_row_d;
    nb_col_q   <= nb_col_d;
    res_q      <= res_d;
  end

  always_comb begin
    logic               in_grid;
    logic [COORD_W-1:0] req_row, req_col;
    logic               nb_ok;
    logic [COORD_W-1:0] nr, nc;
    gap_cell_t          wrec;
    logic [COST_W-1:0]  tg;
    logic               newpath;
    logic               blocked;
    logic               is_end;
    gap_dir_e           back;
    logic               moved;

    state_d    = state_q;
    addr_d     = addr_q;
    rd_vld_d   = 1'b0;
    best_any_d = best_any_q;
    ins_cnt_d  = ins_cnt_q;
    last_len_d = last_len_q;
    dir_d      = dir_q;
    tr_cnt_d   = tr_cnt_q;
    rd_in_d    = rd_in_q;
    scan_row_d = scan_row_q;
    scan_col_d = scan_col_q;
    rd_row_d   = rd_row_q;
    rd_col_d   = rd_col_q;
    best_d     = best_q;
    best_row_d = best_row_q;
    best_col_d = best_col_q;
    nb_row_d   = nb_row_q;
    nb_col_d   = nb_col_q;
    res_d      = res_q;

    cell_we    = 1'b0;
    cell_waddr = '0;
    cell_wdata = '0;
    cell_re    = 1'b0;
    cell_raddr = '0;
    wall_we    = 1'b0;
    wall_waddr = '0;
    wall_wdata = 1'b0;
    wall_re    = 1'b0;
    wall_raddr = '0;

    in_grid = (req_i.row_index < GRID_SIDE) && (req_i.col_index < GRID_SIDE);
    req_row = COORD_W'(req_i.row_index);
    req_col = COORD_W'(req_i.col_index);
    nb_ok   = 1'b0;
    nr      = best_row_q;
    nc      = best_col_q;
    back    = DIR_NONE;
    wrec    = cell_rdata;
    tg      = best_q.cost + COST_W'(1);
    newpath = 1'b0;
    blocked = 1'b0;
    is_end  = 1'b0;
    moved   = 1'b0;

    case (dir_q)
      NB_ROW_INC: begin
        nb_ok = (best_row_q < COORD_W'(GRID_SIDE - 1));
        nr    = best_row_q + COORD_W'(1);
        back  = DIR_ROW_DEC;
      end
      NB_ROW_DEC: begin
        nb_ok = (best_row_q != '0);
        nr    = best_row_q - COORD_W'(1);
        back  = DIR_ROW_INC;
      end
      NB_COL_INC: begin
        nb_ok = (best_col_q < COORD_W'(GRID_SIDE - 1));
        nc    = best_col_q + COORD_W'(1);
        back  = DIR_COL_DEC;
      end
      NB_COL_DEC: begin
        nb_ok = (best_col_q != '0);
        nc    = best_col_q - COORD_W'(1);
        back  = DIR_COL_INC;
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase

    case (state_q)
      S_INIT_CLR: begin
        cell_we    = 1'b1;
        cell_waddr = addr_q[ADDR_W-1:0];
        wall_we    = 1'b1;
        wall_waddr = addr_q[ADDR_W-1:0];
        addr_d     = addr_q + (ADDR_W+1)'(1);
        if (addr_q[ADDR_W-1:0] == ADDR_W'(CELLS - 1)) begin
          addr_d  = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          res_d = '0;
          case (req_i.req_type)
            REQ_LOAD: begin
              wall_we    = in_grid;
              wall_waddr = cell_addr(req_row, req_col);
              wall_wdata = req_i.wall_bit;
              state_d    = S_RESP;
            end
            REQ_SEARCH: begin
              addr_d  = '0;
              state_d = S_CLR;
            end
            REQ_READ: begin
              cell_re    = in_grid;
              cell_raddr = cell_addr(req_row, req_col);
              rd_in_d    = in_grid;
              state_d    = S_READ;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_READ: begin
        res_d.path_length = last_len_q;
        if (rd_in_q) begin
          res_d.cell_closed  = cell_rdata.closed_f;
          res_d.cell_open    = cell_rdata.open_f;
          res_d.cell_on_path = cell_rdata.path_f;
          res_d.came         = cell_rdata.came;
          res_d.cost         = cell_rdata.cost;
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      S_CLR: begin
        cell_we    = 1'b1;
        cell_waddr = addr_q[ADDR_W-1:0];
        addr_d     = addr_q + (ADDR_W+1)'(1);
        if (addr_q[ADDR_W-1:0] == ADDR_W'(CELLS - 1)) begin
          addr_d  = '0;
          state_d = S_START;
        end
      end
      S_START: begin
        ins_cnt_d = '0;
        if (!ends_in) begin
          res_d.status      = STATUS_NONE;
          res_d.path_length = '0;
          last_len_d        = '0;
          state_d           = S_RESP;
        end else begin
          wrec        = '0;
          wrec.open_f = 1'b1;
          wrec.est    = manhattan(s_row, s_col, g_row, g_col);
          cell_we     = 1'b1;
          cell_waddr  = s_addr;
          cell_wdata  = wrec;
          ins_cnt_d   = (ORD_W+1)'(1);
          addr_d      = '0;
          scan_row_d  = '0;
          scan_col_d  = '0;
          best_any_d  = 1'b0;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!addr_q[ADDR_W]) begin
          cell_re    = 1'b1;
          cell_raddr = addr_q[ADDR_W-1:0];
          rd_vld_d   = 1'b1;
          rd_row_d   = scan_row_q;
          rd_col_d   = scan_col_q;
          addr_d     = addr_q + (ADDR_W+1)'(1);
          if (scan_col_q == COORD_W'(GRID_SIDE - 1)) begin
            scan_col_d = '0;
            scan_row_d = scan_row_q + COORD_W'(1);
          end else begin
            scan_col_d = scan_col_q + COORD_W'(1);
          end
        end
        if (rd_vld_q && cell_rdata.open_f &&
            (!best_any_q || (cell_rdata.est < best_q.est) ||
             ((cell_rdata.est == best_q.est) && (cell_rdata.order < best_q.order)))) begin
          best_d     = cell_rdata;
          best_row_d = rd_row_q;
          best_col_d = rd_col_q;
          best_any_d = 1'b1;
        end
        if (addr_q[ADDR_W] && rd_vld_q) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!best_any_q) begin
          res_d.status      = STATUS_NONE;
          res_d.path_length = '0;
          last_len_d        = '0;
          state_d           = S_RESP;
        end else if ((best_row_q == g_row) && (best_col_q == g_col)) begin
          res_d.status      = STATUS_FOUND;
          res_d.path_length = best_q.cost;
          last_len_d        = best_q.cost;
          nb_row_d          = g_row;
          nb_col_d          = g_col;
          tr_cnt_d          = '0;
          state_d           = S_TR_RD;
        end else begin
          wrec          = best_q;
          wrec.open_f   = 1'b0;
          wrec.closed_f = 1'b1;
          cell_we       = 1'b1;
          cell_waddr    = cell_addr(best_row_q, best_col_q);
          cell_wdata    = wrec;
          dir_d         = NB_ROW_INC;
          state_d       = S_NB_RD;
        end
      end
      S_NB_RD: begin
        if (nb_ok) begin
          cell_re    = 1'b1;
          cell_raddr = cell_addr(nr, nc);
          wall_re    = 1'b1;
          wall_raddr = cell_addr(nr, nc);
          nb_row_d   = nr;
          nb_col_d   = nc;
          state_d    = S_NB_WR;
        end else if (dir_q == NB_COL_DEC) begin
          addr_d     = '0;
          scan_row_d = '0;
          scan_col_d = '0;
          best_any_d = 1'b0;
          state_d    = S_SCAN;
        end else begin
          dir_d = gap_nb_e'(dir_q + 2'd1);
        end
      end
      S_NB_WR: begin
        is_end  = (cell_addr(nb_row_q, nb_col_q) == g_addr) ||
                  (cell_addr(nb_row_q, nb_col_q) == s_addr);
        blocked = cell_rdata.closed_f || (wall_rdata && !is_end);
        if (cell_rdata.open_f) begin
          newpath = (tg < cell_rdata.cost);
        end else begin
          wrec.open_f = 1'b1;
          wrec.order  = ins_cnt_q[ORD_W-1:0];
          newpath     = 1'b1;
          if (!blocked) begin
            ins_cnt_d = ins_cnt_q + (ORD_W+1)'(1);
          end
        end
        if (newpath) begin
          wrec.cost = tg;
          wrec.est  = EST_W'(tg) + manhattan(nb_row_q, nb_col_q, g_row, g_col);
          wrec.came = back;
        end
        cell_we    = !blocked;
        cell_waddr = cell_addr(nb_row_q, nb_col_q);
        cell_wdata = wrec;
        if (dir_q == NB_COL_DEC) begin
          addr_d     = '0;
          scan_row_d = '0;
          scan_col_d = '0;
          best_any_d = 1'b0;
          state_d    = S_SCAN;
        end else begin
          dir_d   = gap_nb_e'(dir_q + 2'd1);
          state_d = S_NB_RD;
        end
      end
      S_TR_RD: begin
        cell_re    = 1'b1;
        cell_raddr = cell_addr(nb_row_q, nb_col_q);
        state_d    = S_TR_WR;
      end
      S_TR_WR: begin
        wrec.path_f = 1'b1;
        cell_we     = 1'b1;
        cell_waddr  = cell_addr(nb_row_q, nb_col_q);
        cell_wdata  = wrec;
        tr_cnt_d    = tr_cnt_q + ADDR_W'(1);
        case (cell_rdata.came)
          DIR_ROW_INC: begin
            moved    = (nb_row_q < COORD_W'(GRID_SIDE - 1));
            nb_row_d = nb_row_q + COORD_W'(1);
          end
          DIR_ROW_DEC: begin
            moved    = (nb_row_q != '0);
            nb_row_d = nb_row_q - COORD_W'(1);
          end
          DIR_COL_INC: begin
            moved    = (nb_col_q < COORD_W'(GRID_SIDE - 1));
            nb_col_d = nb_col_q + COORD_W'(1);
          end
          DIR_COL_DEC: begin
            moved    = (nb_col_q != '0);
            nb_col_d = nb_col_q - COORD_W'(1);
          end
          default: begin
            moved = 1'b0;
          end
        endcase
        if ((cell_addr(nb_row_q, nb_col_q) == s_addr) || !moved ||
            (tr_cnt_q == ADDR_W'(CELLS - 1))) begin
          state_d = S_RESP;
        end else begin
          state_d = S_TR_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  `GAP_ASSERT(a_rw_apart, cell_we && cell_re |-> cell_waddr != cell_raddr, "cell ram collision")
  `GAP_ASSERT(a_goal_open, (state_q == S_DECIDE) && cell_we |-> cell_waddr != g_addr, "goal closed")
  `GAP_ASSERT(a_start_when_idle, start_i |-> state_q == S_IDLE, "transaction taken while busy")
  `GAP_ASSERT(a_resp_returns_idle, res_valid_o |=> state_q == S_IDLE, "response not followed by idle")
  `GAP_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |-> res_valid_o !== 1'b1, "result in reset")

endmodule

// ===== hdl/grid_astar_path_search.sv =====
// Top level of the grid path search block: handshakes, configuration registers, result register.
// Depends on gap_pkg and gap_engine.

// A* search on a 64 x 64 grid held in two single-port-per-direction memories (walls, cell
// records). After reset a clearing pass runs before the first item is taken. A wall load or
// unknown request goes straight to its response, and a cell read first waits for the
// registered read data. A search clears the cell memory, then per expanded cell scans the
// whole cell memory for the open cell with the least estimate and visits its neighbors in
// the grid, then walks the path back from the goal, marking each cell on it. One item is in
// progress at a time.
module grid_astar_path_search (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  req_type_i,
  input  logic [gap_pkg::FIELD_W-1:0] row_index_i,
  input  logic [gap_pkg::FIELD_W-1:0] col_index_i,
  input  logic                        wall_bit_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic [gap_pkg::LEN_W-1:0]   path_length_o,
  output logic                        cell_closed_o,
  output logic                        cell_open_o,
  output logic                        cell_on_path_o,
  output logic [2:0]                  cell_came_from_o,
  output logic [gap_pkg::COST_W-1:0]  cell_cost_o,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [gap_pkg::FIELD_W-1:0] cfg_data_i
);
  import gap_pkg::*;

  gap_cfg_t    cfg_q, cfg_d;
  gap_result_t out_q, out_d;
  logic        out_valid_q, out_valid_d;
  gap_req_t    req;
  gap_result_t res;
  logic        res_valid;
  logic        eng_idle;
  logic        start;

  assign req.req_type  = req_type_i;
  assign req.row_index = row_index_i;
  assign req.col_index = col_index_i;
  assign req.wall_bit  = wall_bit_i;

  assign in_ready_o = eng_idle && (!out_valid_q || out_ready_i);
  assign start      = in_valid_i && in_ready_o;

  gap_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_i       (req),
    .cfg_i       (cfg_q),
    .idle_o      (eng_idle),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_START_ROW: cfg_d.start_row = cfg_data_i;
        CFG_START_COL: cfg_d.start_col = cfg_data_i;
        CFG_GOAL_ROW:  cfg_d.goal_row  = cfg_data_i;
        CFG_GOAL_COL:  cfg_d.goal_col  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_d       = res;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_row <= '0;
      cfg_q.start_col <= '0;
      cfg_q.goal_row  <= GOAL_RESET;
      cfg_q.goal_col  <= GOAL_RESET;
      out_valid_q     <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_q.status;
  assign path_length_o    = out_q.path_length;
  assign cell_closed_o    = out_q.cell_closed;
  assign cell_open_o      = out_q.cell_open;
  assign cell_on_path_o   = out_q.cell_on_path;
  assign cell_came_from_o = out_q.came;
  assign cell_cost_o      = out_q.cost;

endmodule
